FILE: hw/rtl/ssv_pkg.sv
// ----------------------------------------------------------------------------
// ssv_pkg
// Shared types and constants of the sensor sample validator.
// ----------------------------------------------------------------------------
package ssv_pkg;

  // Sample and register widths
  localparam int unsigned SampleW = 12;
  localparam int unsigned SpreadW = 13;
  localparam int unsigned NumSamples = 3;

  // Sensor error reading, -127 C in 1/16 C steps
  localparam logic signed [SampleW-1:0] Sentinel = -12'sd2032;

  // Register reset values
  localparam logic signed [SampleW-1:0] MinValidReset  = -12'sd880;
  localparam logic signed [SampleW-1:0] MaxValidReset  = 12'sd2000;
  localparam logic        [SampleW-1:0] MaxSpreadReset = 12'd16;

  // Register indexes (word address)
  localparam logic [1:0] RegMinValid  = 2'd0;
  localparam logic [1:0] RegMaxValid  = 2'd1;
  localparam logic [1:0] RegMaxSpread = 2'd2;

  typedef enum logic [1:0] {
    CauseNone    = 2'd0,
    CauseInvalid = 2'd1,
    CauseSpread  = 2'd2
  } fail_cause_e;

  // Outcome of a complete set of three samples
  typedef struct packed {
    logic signed [SampleW-1:0] mean;
    logic        [SpreadW-1:0] spread;
    logic                      consistent;
  } set_check_t;

endpackage

FILE: hw/rtl/sensor_sample_validator_top.sv
// ----------------------------------------------------------------------------
// sensor_sample_validator_top
// Validates temperature samples in attempts of three and reports the mean.
// ----------------------------------------------------------------------------
// The block takes one sample item per clock cycle, back to back, while
// sample_stall_o is low. The sample that ends an attempt sequence goes into
// the input register, then through the range check, set check and state
// update in a single pass into the result register as a result item. Samples equal to
// the sensor error reading (-127 C) or outside [min_valid, max_valid] abort
// the attempt and drop the samples taken so far. After three good samples the
// mean (rounded to nearest) and the largest |3*s - sum| are formed; a set
// whose spread exceeds 3*max_spread fails. A failed attempt is retried until
// MAX_ATTEMPTS attempts have failed, which gives one failure item; a good set
// gives one success item. The result register parts the two sides, so a new
// sample is taken while a finished result waits; sample_stall_o rises only
// when the result register is full, stalled, and the pending sample would
// produce another result. Registers sit behind an APB-style port at byte
// addresses 0, 4 and 8; write them only while the block is idle.
// ----------------------------------------------------------------------------
module sensor_sample_validator_top #(
  parameter int unsigned MAX_ATTEMPTS = 2
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // sample channel
  input  logic                               sample_valid_i,
  output logic                               sample_stall_o,
  input  logic signed [ssv_pkg::SampleW-1:0] sample_i,
  // result channel
  output logic                               result_valid_o,
  input  logic                               result_stall_i,
  output logic                               read_ok_o,
  output logic signed [ssv_pkg::SampleW-1:0] temperature_o,
  output logic        [ssv_pkg::SpreadW-1:0] spread_times_three_o,
  output logic        [1:0]                  fail_cause_o,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic        [3:0]                  paddr,
  input  logic        [31:0]                 pwdata,
  output logic        [31:0]                 prdata,
  output logic                               pready
);

  localparam int unsigned AttW = (MAX_ATTEMPTS > 1) ? $clog2(MAX_ATTEMPTS) : 1;
  localparam logic [AttW-1:0] LastAttempt = AttW'(MAX_ATTEMPTS - 1);

  // Configuration registers
  logic signed [ssv_pkg::SampleW-1:0] min_valid_q;
  logic signed [ssv_pkg::SampleW-1:0] max_valid_q;
  logic        [ssv_pkg::SampleW-1:0] max_spread_q;
  logic                               cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_valid_q  <= ssv_pkg::MinValidReset;
      max_valid_q  <= ssv_pkg::MaxValidReset;
      max_spread_q <= ssv_pkg::MaxSpreadReset;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        ssv_pkg::RegMinValid:  min_valid_q  <= pwdata[ssv_pkg::SampleW-1:0];
        ssv_pkg::RegMaxValid:  max_valid_q  <= pwdata[ssv_pkg::SampleW-1:0];
        ssv_pkg::RegMaxSpread: max_spread_q <= pwdata[ssv_pkg::SampleW-1:0];
        default: ;  // unmapped word: ignore
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      ssv_pkg::RegMinValid:  prdata = 32'(min_valid_q);
      ssv_pkg::RegMaxValid:  prdata = 32'(max_valid_q);
      ssv_pkg::RegMaxSpread: prdata = {20'd0, max_spread_q};
      default:               prdata = 32'd0;
    endcase
  end

  // Input register
  logic                               in_valid_q;
  logic signed [ssv_pkg::SampleW-1:0] in_sample_q;
  logic                               in_accept;
  logic                               advance;

  // Attempt state
  logic [1:0]                         idx_q, idx_d;
  logic [AttW-1:0]                    attempt_q, attempt_d;
  logic signed [ssv_pkg::SampleW-1:0] sample_store_q [2];

  // Result register
  logic                               res_valid_q;
  logic                               res_ok_q, res_ok_d;
  logic signed [ssv_pkg::SampleW-1:0] res_temp_q, res_temp_d;
  logic        [ssv_pkg::SpreadW-1:0] res_spread_q, res_spread_d;
  ssv_pkg::fail_cause_e               res_cause_q, res_cause_d;
  logic                               emit;

  logic                               bad;
  logic                               last;
  ssv_pkg::set_check_t                check;

  // Advance the pending item unless it would produce a result into a full,
  // stalled result register.
  assign advance        = in_valid_q && (!res_valid_q || !result_stall_i || !emit);
  assign sample_stall_o = in_valid_q && !advance;
  assign in_accept      = sample_valid_i && !sample_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_sample_q <= sample_i;
    end
  end

  ssv_set_check u_set_check (
    .s0_i         (sample_store_q[0]),
    .s1_i         (sample_store_q[1]),
    .s2_i         (in_sample_q),
    .max_spread_i (max_spread_q),
    .check_o      (check)
  );

  assign bad  = (in_sample_q == ssv_pkg::Sentinel) ||
                (in_sample_q < min_valid_q) || (in_sample_q > max_valid_q);
  assign last = (idx_q == 2'(ssv_pkg::NumSamples - 1));

  // Next attempt state and result payload
  always_comb begin
    idx_d        = idx_q;
    attempt_d    = attempt_q;
    emit         = 1'b0;
    res_ok_d     = 1'b0;
    res_temp_d   = '0;
    res_spread_d = '0;
    res_cause_d  = ssv_pkg::CauseNone;
    if (bad || (last && !check.consistent)) begin
      // failed attempt: drop the samples, retry or give up
      idx_d        = 2'd0;
      res_spread_d = bad ? '0 : check.spread;
      res_cause_d  = bad ? ssv_pkg::CauseInvalid : ssv_pkg::CauseSpread;
      if (attempt_q == LastAttempt) begin
        attempt_d = '0;
        emit      = 1'b1;
      end else begin
        attempt_d = attempt_q + AttW'(1);
      end
    end else if (last) begin
      idx_d        = 2'd0;
      attempt_d    = '0;
      emit         = 1'b1;
      res_ok_d     = 1'b1;
      res_temp_d   = check.mean;
      res_spread_d = check.spread;
    end else begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= 2'd0;
      attempt_q <= '0;
    end else if (advance) begin
      idx_q     <= idx_d;
      attempt_q <= attempt_d;
    end
  end

  // Hold good samples of the current attempt
  always_ff @(posedge clk_i) begin
    if (advance && !bad && !last) begin
      sample_store_q[idx_q[0]] <= in_sample_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance && emit) begin
      res_valid_q <= 1'b1;
    end else if (!result_stall_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      res_ok_q     <= res_ok_d;
      res_temp_q   <= res_temp_d;
      res_spread_q <= res_spread_d;
      res_cause_q  <= res_cause_d;
    end
  end

  assign result_valid_o       = res_valid_q;
  assign read_ok_o            = res_ok_q;
  assign temperature_o        = res_temp_q;
  assign spread_times_three_o = res_spread_q;
  assign fail_cause_o         = res_cause_q;

endmodule

FILE: hw/rtl/ssv_set_check.sv
// ----------------------------------------------------------------------------
// ssv_set_check
// Sum, rounded mean and largest deviation of a set of three samples.
// ----------------------------------------------------------------------------
module ssv_set_check (
  input  logic signed [ssv_pkg::SampleW-1:0] s0_i,
  input  logic signed [ssv_pkg::SampleW-1:0] s1_i,
  input  logic signed [ssv_pkg::SampleW-1:0] s2_i,
  input  logic        [ssv_pkg::SampleW-1:0] max_spread_i,
  output ssv_pkg::set_check_t                check_o
);

  // Reciprocal of three in 16 fractional bits, exact for the sum range used
  localparam logic [15:0] RecipThree = 16'd21846;

  logic signed [13:0] sum;
  logic signed [15:0] d0, d1, d2;
  logic        [15:0] a0, a1, a2;
  logic        [12:0] m01, m012;
  logic        [13:0] limit3;
  logic        [13:0] mag;
  logic        [13:0] mag_p1;
  logic        [29:0] prod;
  logic        [13:0] quot;
  logic        [13:0] mean_w;

  assign sum = 14'(s0_i) + 14'(s1_i) + 14'(s2_i);

  // deviation of each sample scaled by three
  assign d0 = (16'(s0_i) <<< 1) + 16'(s0_i) - 16'(sum);
  assign d1 = (16'(s1_i) <<< 1) + 16'(s1_i) - 16'(sum);
  assign d2 = (16'(s2_i) <<< 1) + 16'(s2_i) - 16'(sum);

  assign a0 = d0[15] ? 16'(-d0) : 16'(d0);
  assign a1 = d1[15] ? 16'(-d1) : 16'(d1);
  assign a2 = d2[15] ? 16'(-d2) : 16'(d2);

  assign m01  = (a0[12:0] > a1[12:0]) ? a0[12:0] : a1[12:0];
  assign m012 = (m01 > a2[12:0]) ? m01 : a2[12:0];

  assign limit3 = {1'b0, max_spread_i, 1'b0} + {2'b00, max_spread_i};

  // round to nearest, symmetric about zero: sign * floor((|sum| + 1) / 3)
  assign mag    = sum[13] ? 14'(-sum) : 14'(sum);
  assign mag_p1 = mag + 14'd1;
  assign prod   = 30'(mag_p1) * 30'(RecipThree);
  assign quot   = prod[29:16];
  assign mean_w = sum[13] ? 14'(-quot) : quot;

  assign check_o.mean       = mean_w[ssv_pkg::SampleW-1:0];
  assign check_o.spread     = m012;
  assign check_o.consistent = ({1'b0, m012} <= limit3);

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sensor_sample_validator_top: sample items go in
// through a gapped driver, results are checked against a local model of the
// three-sample validation, retry and averaging rules.
// ----------------------------------------------------------------------------
// Flow: reset, a directed run at the reset window, then random runs under
// several register settings (full range, zero spread, empty window, a window
// that holds the sensor error reading, random windows). Registers are
// programmed and read back only once the block has drained.
// ----------------------------------------------------------------------------
module tb;

  localparam int Attempts = 2;

  // One expected result item
  typedef struct packed {
    logic                               read_ok;
    logic signed [ssv_pkg::SampleW-1:0] temperature;
    logic        [ssv_pkg::SpreadW-1:0] spread;
    ssv_pkg::fail_cause_e               cause;
  } reading_t;

  // One pending sample item; drain_first holds it back until no result is due
  typedef struct {
    logic signed [ssv_pkg::SampleW-1:0] value;
    bit                                 drain_first;
  } sample_item_t;

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               sample_valid_i = 1'b0;
  logic                               sample_stall_o;
  logic signed [ssv_pkg::SampleW-1:0] sample_i = '0;
  logic                               result_valid_o;
  logic                               result_stall_i = 1'b0;
  logic                               read_ok_o;
  logic signed [ssv_pkg::SampleW-1:0] temperature_o;
  logic        [ssv_pkg::SpreadW-1:0] spread_times_three_o;
  logic        [1:0]                  fail_cause_o;
  logic                               psel = 1'b0;
  logic                               penable = 1'b0;
  logic                               pwrite = 1'b0;
  logic        [3:0]                  paddr = '0;
  logic        [31:0]                 pwdata = '0;
  logic        [31:0]                 prdata;
  logic                               pready;

  sensor_sample_validator_top #(
    .MAX_ATTEMPTS(Attempts)
  ) u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .sample_valid_i      (sample_valid_i),
    .sample_stall_o      (sample_stall_o),
    .sample_i            (sample_i),
    .result_valid_o      (result_valid_o),
    .result_stall_i      (result_stall_i),
    .read_ok_o           (read_ok_o),
    .temperature_o       (temperature_o),
    .spread_times_three_o(spread_times_three_o),
    .fail_cause_o        (fail_cause_o),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Local copy of the registers and of the attempt state
  logic signed [ssv_pkg::SampleW-1:0] win_min;
  logic signed [ssv_pkg::SampleW-1:0] win_max;
  logic        [ssv_pkg::SampleW-1:0] spread_limit;
  logic signed [ssv_pkg::SampleW-1:0] held_samples[ssv_pkg::NumSamples];
  int                                 good_count;
  int                                 attempt_count;

  sample_item_t sample_backlog[$];
  reading_t     expected_readings[$];
  int           error_count = 0;
  bit           sample_taken = 1'b0;
  bit           quiet = 1'b0;
  int           send_gap = 0;
  int           stall_left = 0;

  // Print one line per mismatch and count it
  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  // Close a failed attempt; give a failure item once the retries are used up
  function automatic bit close_failed_attempt(input int spread,
                                              input ssv_pkg::fail_cause_e cause,
                                              output reading_t r);
    r = '0;
    good_count = 0;
    if (attempt_count + 1 >= Attempts) begin
      attempt_count = 0;
      r.read_ok = 1'b0;
      r.temperature = '0;
      r.spread = spread[ssv_pkg::SpreadW-1:0];
      r.cause = cause;
      return 1'b1;
    end
    attempt_count++;
    return 1'b0;
  endfunction

  // Advance the attempt state by one sample; return 1 with the result it gives
  function automatic bit validate_reading(input logic signed [ssv_pkg::SampleW-1:0] s,
                                          output reading_t r);
    int sum;
    int worst;
    int dev;
    int mean;
    r = '0;
    if (s == ssv_pkg::Sentinel || s < win_min || s > win_max) begin
      return close_failed_attempt(0, ssv_pkg::CauseInvalid, r);
    end
    held_samples[good_count] = s;
    good_count++;
    if (good_count < ssv_pkg::NumSamples) return 1'b0;

    sum = 0;
    worst = 0;
    for (int i = 0; i < ssv_pkg::NumSamples; i++) sum += int'(held_samples[i]);
    for (int i = 0; i < ssv_pkg::NumSamples; i++) begin
      dev = 3 * int'(held_samples[i]) - sum;
      if (dev < 0) dev = -dev;
      if (dev > worst) worst = dev;
    end
    if (worst > 3 * int'(spread_limit)) begin
      return close_failed_attempt(worst, ssv_pkg::CauseSpread, r);
    end
    // Round the mean to nearest, symmetric about zero
    mean = (sum >= 0) ? (sum + 1) / 3 : -((1 - sum) / 3);
    good_count = 0;
    attempt_count = 0;
    r.read_ok = 1'b1;
    r.temperature = mean[ssv_pkg::SampleW-1:0];
    r.spread = worst[ssv_pkg::SpreadW-1:0];
    r.cause = ssv_pkg::CauseNone;
    return 1'b1;
  endfunction

  // Idle length: mostly a few cycles, now and then a long stretch
  function automatic int idle_length();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Sample driver: change inputs on the falling edge, hold a stalled item
  always @(negedge clk_i) begin : drive_samples
    sample_item_t item;
    if (!rst_ni) begin
      sample_valid_i <= 1'b0;
    end else if (!sample_valid_i || sample_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        sample_valid_i <= 1'b0;
      end else if (sample_backlog.size() != 0 &&
                   !(sample_backlog[0].drain_first && expected_readings.size() != 0)) begin
        item = sample_backlog.pop_front();
        sample_valid_i <= 1'b1;
        sample_i <= item.value;
        // Draw the gap that follows this item
        if (quiet || $urandom_range(0, 99) < 60) send_gap = 0;
        else send_gap = idle_length();
      end else begin
        sample_valid_i <= 1'b0;
      end
    end
  end

  // Result back-pressure: random stall bursts, none while quiet
  always @(negedge clk_i) begin
    if (!rst_ni || quiet) begin
      stall_left = 0;
      result_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      result_stall_i <= 1'b1;
    end else if ($urandom_range(0, 9) < 2) begin
      stall_left = idle_length() - 1;
      result_stall_i <= 1'b1;
    end else begin
      result_stall_i <= 1'b0;
    end
  end

  // Monitor: predict on each accepted sample, check each accepted result
  always @(posedge clk_i) begin : check_results
    reading_t predicted;
    reading_t want;
    if (rst_ni) begin
      sample_taken = sample_valid_i && !sample_stall_o;
      if (sample_taken && validate_reading(sample_i, predicted)) begin
        expected_readings.push_back(predicted);
      end
      if (result_valid_o && !result_stall_i) begin
        if (expected_readings.size() == 0) begin
          report_mismatch($sformatf("result with none due: ok=%0b temp=%0d spread=%0d cause=%0d",
                                    read_ok_o, temperature_o, spread_times_three_o,
                                    fail_cause_o));
        end else begin
          want = expected_readings.pop_front();
          if (read_ok_o !== want.read_ok)
            report_mismatch($sformatf("read_ok %b, want %b", read_ok_o, want.read_ok));
          if (temperature_o !== want.temperature)
            report_mismatch($sformatf("temperature %0d, want %0d", temperature_o,
                                      want.temperature));
          if (spread_times_three_o !== want.spread)
            report_mismatch($sformatf("spread_times_three %0d, want %0d",
                                      spread_times_three_o, want.spread));
          if (fail_cause_o !== want.cause)
            report_mismatch($sformatf("fail_cause %0d, want %0d", fail_cause_o,
                                      want.cause));
        end
      end
    end
  end

  // Queue one sample item
  function automatic void push_sample(input int value, input bit drain_first = 1'b0);
    sample_item_t item;
    item.value = value[ssv_pkg::SampleW-1:0];
    item.drain_first = drain_first;
    sample_backlog.push_back(item);
  endfunction

  function automatic int clamp(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // A sample that aborts the attempt: the error reading or one outside the window
  function automatic int bad_sample();
    if ($urandom_range(0, 1) == 0) return int'(ssv_pkg::Sentinel);
    if (int'(win_min) > -2048 && $urandom_range(0, 1) == 0)
      return $urandom_range(0, int'(win_min) + 2047) - 2048;
    if (int'(win_max) < 2047) return int'(win_max) + 1 + $urandom_range(0, 2046 - int'(win_max));
    return int'(ssv_pkg::Sentinel);
  endfunction

  // Random part: mostly well-formed sets around a random center, some broken
  // attempts and some raw noise over the full 12-bit range
  task automatic queue_random_sets(input int count);
    int queued;
    int kind;
    int center;
    int dev;
    int lo;
    int hi;
    int taken;
    queued = 0;
    lo = int'(win_min);
    hi = int'(win_max);
    while (queued < count) begin
      kind = $urandom_range(0, 99);
      if (lo > hi || kind >= 90) begin
        push_sample(int'($urandom_range(0, 4095)) - 2048);
        queued++;
      end else begin
        center = lo + $urandom_range(0, hi - lo);
        dev = clamp($urandom_range(0, 2 * int'(spread_limit) + 2), 0, 4095);
        taken = (kind < 75) ? ssv_pkg::NumSamples : $urandom_range(0, ssv_pkg::NumSamples - 1);
        for (int k = 0; k < taken; k++) begin
          push_sample(clamp(center + $urandom_range(0, 2 * dev) - dev, lo, hi));
        end
        queued += taken;
        if (taken < ssv_pkg::NumSamples) begin
          push_sample(bad_sample());
          queued++;
        end
      end
    end
  endtask

  // Wait until every item went in and every result came out, then let the
  // pipeline empty
  task automatic settle();
    while (sample_backlog.size() != 0 || sample_valid_i || expected_readings.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write one register, read it back and update the local copy
  task automatic program_register(input logic [1:0] index,
                                  input logic [ssv_pkg::SampleW-1:0] value);
    logic [31:0] word;
    word = $urandom;
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= {word[31:ssv_pkg::SampleW], value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (index)
      ssv_pkg::RegMinValid:  win_min = value;
      ssv_pkg::RegMaxValid:  win_max = value;
      ssv_pkg::RegMaxSpread: spread_limit = value;
      default: ;
    endcase
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[ssv_pkg::SampleW-1:0] !== value)
      report_mismatch($sformatf("register %0d read %h, want %h", index,
                                prdata[ssv_pkg::SampleW-1:0], value));
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_window(input int lo, input int hi, input int limit);
    program_register(ssv_pkg::RegMinValid, lo[ssv_pkg::SampleW-1:0]);
    program_register(ssv_pkg::RegMaxValid, hi[ssv_pkg::SampleW-1:0]);
    program_register(ssv_pkg::RegMaxSpread, limit[ssv_pkg::SampleW-1:0]);
  endtask

  // Safety net against a hung handshake
  initial begin
    #5000000;
    $display("sensor_sample_validator_top regression: fail");
    $finish;
  end

  initial begin
    int lo;
    win_min = ssv_pkg::MinValidReset;
    win_max = ssv_pkg::MaxValidReset;
    spread_limit = ssv_pkg::MaxSpreadReset;
    good_count = 0;
    attempt_count = 0;
    // Hold reset, release on a falling edge
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed run at the reset window [-880, 2000], spread 16
    push_sample(100); push_sample(100); push_sample(100);     // equal set
    push_sample(0); push_sample(0); push_sample(1);           // mean rounds down
    push_sample(-1); push_sample(-1); push_sample(0);         // negative rounding
    push_sample(0); push_sample(0); push_sample(100);         // inconsistent, retry
    push_sample(0); push_sample(0); push_sample(100);         // inconsistent again
    push_sample(2047, 1'b1);                                  // above window, after drain
    push_sample(-881);                                        // below window, final fail
    push_sample(1); push_sample(2); push_sample(-2048);       // abort a partial set
    push_sample(2000); push_sample(2000); push_sample(1999);  // top edge of window
    push_sample(-880); push_sample(-880); push_sample(-879);  // bottom edge
    queue_random_sets(330);
    settle();

    // Full range, widest spread: only the error reading is rejected
    set_window(-2048, 2047, 4095);
    push_sample(2047); push_sample(2047); push_sample(2047);
    push_sample(-2048); push_sample(-2048); push_sample(-2048);
    push_sample(-2048); push_sample(2047); push_sample(2047);  // largest spread
    push_sample(int'(ssv_pkg::Sentinel)); push_sample(int'(ssv_pkg::Sentinel));
    queue_random_sets(300);
    settle();

    // Zero spread, no idling on either side
    quiet = 1'b1;
    set_window(-2048, 2047, 0);
    queue_random_sets(250);
    settle();
    quiet = 1'b0;

    // Empty window: every sample aborts
    set_window(2047, -2048, 7);
    queue_random_sets(60);
    settle();

    // Window that holds the error reading, which must still be rejected
    set_window(int'(ssv_pkg::Sentinel), -1900, 3);
    push_sample(int'(ssv_pkg::Sentinel)); push_sample(int'(ssv_pkg::Sentinel));
    push_sample(-2031); push_sample(-2031); push_sample(-2030);
    queue_random_sets(150);
    settle();

    // Random windows with small spreads
    repeat (4) begin
      lo = int'($urandom_range(0, 4095)) - 2048;
      set_window(lo, clamp(lo + $urandom_range(0, 600), -2048, 2047), $urandom_range(0, 40));
      queue_random_sets(150);
      settle();
    end

    if (error_count == 0) begin
      $display("sensor_sample_validator_top regression: pass");
    end else begin
      $display("sensor_sample_validator_top regression: fail");
    end
    $finish;
  end

endmodule
